/* rtl/cim_pkg.sv */
// Package for the cell imbalance monitor: field widths, defaults and shared types.
// Used by the channel interfaces, the scan tracker and the top level.
package cim_pkg;

    // Fixed field widths of the channels.
    localparam int CODE_W     = 16;
    localparam int THRESH_W   = 16;
    localparam int CELL_OUT_W = 7;

    // Defaults for the top-level parameters.
    localparam int MAX_CELLS_DEF = 128;
    localparam int CODE_BITS_DEF = 16;

    // Threshold after reset.
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(655);

    // One sample as it moves through the block.
    typedef struct packed {
        logic [CODE_W-1:0] cell_code;
        logic              module_valid;
        logic              last_cell;
    } cim_sample_t;

    // One scan summary.
    typedef struct packed {
        logic [CELL_OUT_W-1:0] min_cell;
        logic [CELL_OUT_W-1:0] max_cell;
        logic                  imbalance_fault;
        logic                  all_valid;
        logic                  any_valid;
    } cim_result_t;

endpackage

/* rtl/cim_if.sv */
// Valid/ready channel interfaces of the cell imbalance monitor.
// Depends on cim_pkg for field widths.
interface cim_sample_if import cim_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] cell_code;
    logic              module_valid;
    logic              last_cell;

    modport source (output valid, cell_code, module_valid, last_cell, input ready);
    modport sink   (input valid, cell_code, module_valid, last_cell, output ready);
endinterface

interface cim_result_if import cim_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CELL_OUT_W-1:0] min_cell;
    logic [CELL_OUT_W-1:0] max_cell;
    logic                  imbalance_fault;
    logic                  all_valid;
    logic                  any_valid;

    modport source (output valid, min_cell, max_cell, imbalance_fault, all_valid, any_valid,
                    input ready);
    modport sink   (input valid, min_cell, max_cell, imbalance_fault, all_valid, any_valid,
                    output ready);
endinterface

interface cim_cfg_if import cim_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/cell_imbalance_monitor.sv */
// Top level of the cell imbalance monitor: input register, scan tracker and
// result register. Depends on cim_pkg, cim_if and cim_tracker.
//
// The block takes one cell voltage code per transaction on samples and keeps the
// lowest and highest valid codes of the scan with the cell numbers that hold
// them, numbering cells from 0 and holding the number at MAX_CELLS-1 once it is
// reached. Cell numbers are reported in 7 bits. A sample whose module_valid is
// low only clears all_valid. The transaction marked last_cell closes the scan:
// one summary transaction appears on report and the tracker starts the next scan
// from its reset state. imbalance_fault is set when at least one valid sample was
// seen and highest minus lowest code exceeds the threshold written on cfg (655
// after reset); cfg is always ready and should be written only while the block
// is idle. Codes are masked to CODE_BITS. One sample is accepted every clock
// cycle, stalled only when a closing sample meets a summary that report has not
// yet taken; a summary is loaded into the result register when its closing sample
// leaves the input register. The rate is set by the compare and update of the
// running minimum and maximum between the input register and the tracker state.
module cell_imbalance_monitor import cim_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    cim_cfg_if.sink        cfg,
    cim_sample_if.sink     samples,
    cim_result_if.source   report
);

    logic [THRESH_W-1:0] threshold_reg;

    logic        stage_valid_reg;
    cim_sample_t stage_item_reg;

    logic        report_valid_reg;
    cim_result_t report_reg;

    cim_sample_t incoming;
    cim_result_t summary;
    logic        report_free;
    logic        advance;

    // Threshold register; the port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            threshold_reg <= cfg.data;
        end
    end

    // Input register. A sample that does not close the scan always moves on;
    // a closing one needs room in the result register.
    assign report_free = !report_valid_reg || report.ready;
    assign advance     = stage_valid_reg && (!stage_item_reg.last_cell || report_free);
    assign samples.ready = !stage_valid_reg || advance;

    always_comb
    begin
        incoming.cell_code    = samples.cell_code;
        incoming.module_valid = samples.module_valid;
        incoming.last_cell    = samples.last_cell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            stage_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            stage_item_reg <= incoming;
        end
    end

    cim_tracker #(
        .MAX_CELLS (MAX_CELLS),
        .CODE_BITS (CODE_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .sample    (stage_item_reg),
        .threshold (threshold_reg),
        .result    (summary)
    );

    // Result register: load on a closing sample, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (advance && stage_item_reg.last_cell)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_item_reg.last_cell)
        begin
            report_reg <= summary;
        end
    end

    assign report.valid           = report_valid_reg;
    assign report.min_cell        = report_reg.min_cell;
    assign report.max_cell        = report_reg.max_cell;
    assign report.imbalance_fault = report_reg.imbalance_fault;
    assign report.all_valid       = report_reg.all_valid;
    assign report.any_valid       = report_reg.any_valid;

endmodule

/* rtl/cim_tracker.sv */
// Scan tracker: running minimum and maximum codes, their cell numbers and the
// validity flags of one scan. Depends on cim_pkg.
module cim_tracker import cim_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cim_sample_t         sample,
    input  logic [THRESH_W-1:0] threshold,
    output cim_result_t         result
);

    localparam int CIW = $clog2(MAX_CELLS);
    localparam int CW  = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
    localparam logic [CIW-1:0] TOP_CELL = CIW'(MAX_CELLS - 1);

    logic [CIW-1:0] cell_number_reg, cell_number_next;
    logic [CW-1:0]  lowest_code_reg, lowest_code_next;
    logic [CW-1:0]  highest_code_reg, highest_code_next;
    logic [CIW-1:0] lowest_index_reg, lowest_index_next;
    logic [CIW-1:0] highest_index_reg, highest_index_next;
    logic           seen_valid_reg, seen_valid_next;
    logic           every_valid_reg, every_valid_next;

    logic [CW-1:0] code;
    logic          take_low;
    logic          take_high;
    logic [CW-1:0] spread;

    assign code      = sample.cell_code[CW-1:0];
    assign take_low  = sample.module_valid && (!seen_valid_reg || code < lowest_code_reg);
    assign take_high = sample.module_valid && (!seen_valid_reg || code > highest_code_reg);

    always_comb
    begin
        lowest_code_next   = take_low  ? code : lowest_code_reg;
        lowest_index_next  = take_low  ? cell_number_reg : lowest_index_reg;
        highest_code_next  = take_high ? code : highest_code_reg;
        highest_index_next = take_high ? cell_number_reg : highest_index_reg;
        seen_valid_next    = seen_valid_reg | sample.module_valid;
        every_valid_next   = every_valid_reg & sample.module_valid;
        // Saturate at the top cell number.
        cell_number_next   = (cell_number_reg != TOP_CELL) ? cell_number_reg + 1'b1
                                                           : cell_number_reg;
    end

    assign spread = highest_code_next - lowest_code_next;

    always_comb
    begin
        result.min_cell        = CELL_OUT_W'(lowest_index_next);
        result.max_cell        = CELL_OUT_W'(highest_index_next);
        result.imbalance_fault = seen_valid_next && (THRESH_W'(spread) > threshold);
        result.all_valid       = every_valid_next;
        result.any_valid       = seen_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_number_reg   <= '0;
            lowest_code_reg   <= '0;
            highest_code_reg  <= '0;
            lowest_index_reg  <= '0;
            highest_index_reg <= '0;
            seen_valid_reg    <= 1'b0;
            every_valid_reg   <= 1'b1;
        end
        else if (step)
        begin
            if (sample.last_cell)
            begin
                // End of scan: start the next one afresh.
                cell_number_reg   <= '0;
                lowest_code_reg   <= '0;
                highest_code_reg  <= '0;
                lowest_index_reg  <= '0;
                highest_index_reg <= '0;
                seen_valid_reg    <= 1'b0;
                every_valid_reg   <= 1'b1;
            end
            else
            begin
                cell_number_reg   <= cell_number_next;
                lowest_code_reg   <= lowest_code_next;
                highest_code_reg  <= highest_code_next;
                lowest_index_reg  <= lowest_index_next;
                highest_index_reg <= highest_index_next;
                seen_valid_reg    <= seen_valid_next;
                every_valid_reg   <= every_valid_next;
            end
        end
    end

endmodule

/* rtl/cim_checker.sv */
// Port-level checks for the cell imbalance monitor, bound to the top level.
// Depends on cim_pkg and the top-level ports.
module cim_checker import cim_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rep_valid,
    input logic                  rep_ready,
    input logic [CELL_OUT_W-1:0] rep_min_cell,
    input logic [CELL_OUT_W-1:0] rep_max_cell,
    input logic                  rep_fault,
    input logic                  rep_all_valid,
    input logic                  rep_any_valid
);

    // Hold a summary until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=> rep_valid)
        else $error("summary dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=>
            $stable(rep_min_cell) && $stable(rep_max_cell) && $stable(rep_fault))
        else $error("summary changed while stalled");

    // A scan without valid data names no cells and raises no fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_any_valid |->
            !rep_fault && rep_min_cell == '0 && rep_max_cell == '0)
        else $error("summary without valid data is not empty");

    // A scan has at least one sample, so all valid implies some valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && rep_all_valid |-> rep_any_valid)
        else $error("all_valid set without any_valid");

endmodule

bind cell_imbalance_monitor cim_checker u_cim_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rep_valid     (report.valid),
    .rep_ready     (report.ready),
    .rep_min_cell  (report.min_cell),
    .rep_max_cell  (report.max_cell),
    .rep_fault     (report.imbalance_fault),
    .rep_all_valid (report.all_valid),
    .rep_any_valid (report.any_valid)
);

/* dv/testbench.sv */
// Self-checking testbench for cell_imbalance_monitor: streams scans of cell codes, predicts
// the summary of each scan and compares it field by field with the report channel.
// Depends on cim_pkg, the channel interfaces in cim_if and the RTL of the block.
module testbench import cim_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Cell numbers stop at the last cell of the default configuration.
    localparam int N_CELLS      = MAX_CELLS_DEF;
    localparam int CODE_MAX     = (1 << CODE_W) - 1;
    // Cycles to let pass once the last summary is in, as a margin for the block to settle.
    localparam int SETTLE_CYCLES = 6;
    // Generous bound: every item with its longest gap and longest report stall, many times over.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 140;

    // Receiver behaviour on the report channel.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } stall_mode_e;

    logic clk;
    logic rst_n;

    cim_cfg_if    cfg_ch ();
    cim_sample_if sample_ch ();
    cim_result_if report_ch ();

    cell_imbalance_monitor i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .report  (report_ch)
    );

    // Shadow of the scan tracker: running extremes, their cell numbers and the flags.
    logic [THRESH_W-1:0]   threshold;
    int unsigned           scan_cell;
    logic [CODE_W-1:0]     lowest_code;
    logic [CODE_W-1:0]     highest_code;
    logic [CELL_OUT_W-1:0] lowest_cell;
    logic [CELL_OUT_W-1:0] highest_cell;
    logic                  seen_valid;
    logic                  every_valid;

    cim_result_t pending_summaries[$];
    cim_result_t oldest_summary;

    int          mismatches;
    int unsigned cycle_count;
    int unsigned items_sent;
    int          burst_left;
    bit          sender_gaps;
    stall_mode_e stall_mode;
    int          stall_tick;
    int          stall_hold;

    // Free-running clock, 20 ns period.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop: a hung handshake or a lost summary ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Report channel back-pressure; the pattern follows the mode set by the current test.
    always @(posedge clk)
    begin
        case (stall_mode)
            STALL_NONE:
                report_ch.ready <= 1'b1;
            STALL_RANDOM:
                report_ch.ready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC:
            begin
                stall_tick      <= stall_tick + 1;
                report_ch.ready <= ((stall_tick % 8) < 5);
            end
            default:
            begin
                // Hold ready low for long stretches, with short windows of acceptance.
                if (stall_hold > 0)
                    stall_hold <= stall_hold - 1;
                else if (report_ch.ready)
                begin
                    report_ch.ready <= 1'b0;
                    stall_hold      <= $urandom_range(5, 25);
                end
                else
                begin
                    report_ch.ready <= 1'b1;
                    stall_hold      <= $urandom_range(1, 4);
                end
            end
        endcase
    end

    function automatic void compare_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Check every summary transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (pending_summaries.size() == 0)
            begin
                $display("%0t: summary with none expected, expected none actual min %0d max %0d",
                         $time, report_ch.min_cell, report_ch.max_cell);
                mismatches++;
            end
            else
            begin
                oldest_summary = pending_summaries.pop_front();
                compare_field("min_cell", oldest_summary.min_cell, report_ch.min_cell);
                compare_field("max_cell", oldest_summary.max_cell, report_ch.max_cell);
                compare_field("imbalance_fault", oldest_summary.imbalance_fault,
                              report_ch.imbalance_fault);
                compare_field("all_valid", oldest_summary.all_valid, report_ch.all_valid);
                compare_field("any_valid", oldest_summary.any_valid, report_ch.any_valid);
            end
        end
    end

    function automatic void clear_scan();
        scan_cell    = 0;
        lowest_code  = '0;
        highest_code = '0;
        lowest_cell  = '0;
        highest_cell = '0;
        seen_valid   = 1'b0;
        every_valid  = 1'b1;
    endfunction

    // Fold one accepted sample into the shadow state; queue a summary when it closes the scan.
    function automatic void track_cell(cim_sample_t s);
        cim_result_t summary;
        if (s.module_valid)
        begin
            // Only a strictly lower or higher code moves a place, so ties keep the earliest cell.
            if (!seen_valid || s.cell_code < lowest_code)
            begin
                lowest_code = s.cell_code;
                lowest_cell = scan_cell[CELL_OUT_W-1:0];
            end
            if (!seen_valid || s.cell_code > highest_code)
            begin
                highest_code = s.cell_code;
                highest_cell = scan_cell[CELL_OUT_W-1:0];
            end
            seen_valid = 1'b1;
        end
        else
            every_valid = 1'b0;

        if (scan_cell < N_CELLS - 1)
            scan_cell++;

        if (s.last_cell)
        begin
            summary.min_cell        = lowest_cell;
            summary.max_cell        = highest_cell;
            summary.imbalance_fault = seen_valid && ((highest_code - lowest_code) > threshold);
            summary.all_valid       = every_valid;
            summary.any_valid       = seen_valid;
            pending_summaries.push_back(summary);
            clear_scan();
        end
    endfunction

    // Send one sample transaction; open a new burst, after a random gap, when the last runs out.
    // Call at a rising edge; returns at the edge that accepted the sample.
    task automatic push_sample(logic [CODE_W-1:0] code, logic mod_valid, logic last);
        cim_sample_t s;
        int gap;
        if (burst_left <= 0)
        begin
            gap        = sender_gaps ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s.cell_code    = code;
        s.module_valid = mod_valid;
        s.last_cell    = last;
        sample_ch.valid        <= 1'b1;
        sample_ch.cell_code    <= code;
        sample_ch.module_valid <= mod_valid;
        sample_ch.last_cell    <= last;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        burst_left--;
        items_sent++;
        track_cell(s);
    endtask

    // Drop valid and wait until every summary is in, then let the pipeline settle.
    task automatic drain_scans();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the threshold register; only called with the block idle.
    task automatic set_threshold(logic [THRESH_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        threshold = value;
    endtask

    // Code near base, with an occasional jump to either end of the range.
    function automatic logic [CODE_W-1:0] pick_code(int unsigned base, int unsigned spread);
        int unsigned v;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? CODE_W'(CODE_MAX) : '0;
        v = base + $urandom_range(0, spread);
        if (v > CODE_MAX)
            v = CODE_MAX;
        return v[CODE_W-1:0];
    endfunction

    // One scan of random content: codes within spread of a random base, some samples invalid.
    task automatic send_scan(int len, int invalid_pct, int unsigned spread);
        int unsigned base;
        base = $urandom_range(0, CODE_MAX - spread);
        for (int i = 0; i < len; i++)
            push_sample(pick_code(base, spread), $urandom_range(0, 99) >= invalid_pct,
                        i == len - 1);
    endtask

    // Threshold left at its reset value: a spread just at it, then one above it.
    task automatic test_reset_threshold();
        push_sample(16'd1000, 1'b1, 1'b0);
        push_sample(16'd1655, 1'b1, 1'b1);
        push_sample(16'd1656, 1'b1, 1'b0);
        push_sample(16'd1000, 1'b1, 1'b1);
        drain_scans();
    endtask

    // Scans of one sample, scans with no valid data and invalid samples mixed in.
    task automatic test_validity();
        // A single sample sets both the lowest and the highest place.
        push_sample(16'd4321, 1'b1, 1'b1);
        push_sample(16'd4321, 1'b0, 1'b1);
        // No valid data at all: no fault however far apart the codes.
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'hFFFF, 1'b0, 1'b0);
        push_sample(16'h1234, 1'b0, 1'b1);
        // Invalid samples only clear all_valid; their codes are ignored.
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'h8000, 1'b1, 1'b0);
        push_sample(16'hFFFF, 1'b0, 1'b1);
        drain_scans();
    endtask

    // Codes at both ends of the range in both orders, and ties.
    task automatic test_extreme_codes();
        push_sample(16'h0000, 1'b1, 1'b0);
        push_sample(16'hFFFF, 1'b1, 1'b1);
        push_sample(16'hFFFF, 1'b1, 1'b0);
        push_sample(16'h0000, 1'b1, 1'b1);
        // Equal codes: the earliest cell holds both places.
        push_sample(16'd100, 1'b1, 1'b0);
        push_sample(16'd100, 1'b1, 1'b0);
        push_sample(16'd100, 1'b1, 1'b1);
        drain_scans();
    endtask

    // Thresholds at both ends of the register's range.
    task automatic test_threshold_limits();
        set_threshold('0);
        push_sample(16'd500, 1'b1, 1'b0);
        push_sample(16'd500, 1'b1, 1'b1);
        push_sample(16'd500, 1'b1, 1'b0);
        push_sample(16'd501, 1'b1, 1'b1);
        drain_scans();
        set_threshold('1);
        push_sample(16'h0000, 1'b1, 1'b0);
        push_sample(16'hFFFF, 1'b1, 1'b1);
        drain_scans();
    endtask

    // More samples than cells: late extremes all share the top cell number, and the next
    // scan starts numbering from zero again.
    task automatic test_cell_saturation();
        set_threshold(THRESH_RESET);
        for (int i = 0; i < 150; i++)
        begin
            if (i == 135)
                push_sample(16'hFFFF, 1'b1, 1'b0);
            else if (i == 140)
                push_sample(16'h0000, 1'b1, 1'b0);
            else
                push_sample(CODE_W'(30000 + $urandom_range(0, 100)), 1'b1, i == 149);
        end
        push_sample(16'd2000, 1'b1, 1'b0);
        push_sample(16'd1000, 1'b1, 1'b1);
        drain_scans();
    endtask

    // Phases of random scans, each with its own threshold, sender gaps and report stalls.
    task automatic test_random_scans();
        int unsigned start;
        int len;
        int invalid_pct;
        int spread;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:       set_threshold('0);
                1:       set_threshold('1);
                2:       set_threshold(THRESH_RESET);
                3:       set_threshold(THRESH_W'($urandom_range(0, 1000)));
                4:       set_threshold(THRESH_W'(1));
                5:       set_threshold(THRESH_W'(CODE_MAX - 1));
                default: set_threshold(THRESH_W'($urandom_range(0, CODE_MAX)));
            endcase
            stall_mode  = stall_mode_e'(phase % 4);
            // One phase streams back to back with no sender gaps.
            sender_gaps = (phase != 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 170)
                                                  : $urandom_range(1, 24);
                case ($urandom_range(0, 5))
                    0:       invalid_pct = 10;
                    1:       invalid_pct = 50;
                    2:       invalid_pct = 100;
                    default: invalid_pct = 0;
                endcase
                // Spreads that straddle the threshold, near-ties and the whole code range.
                case ($urandom_range(0, 3))
                    0:       spread = $urandom_range(0, 3);
                    1:       spread = int'(threshold) + $urandom_range(0, 4) - 2;
                    2:       spread = CODE_MAX;
                    default: spread = $urandom_range(0, CODE_MAX);
                endcase
                if (spread < 0)
                    spread = 0;
                if (spread > CODE_MAX)
                    spread = CODE_MAX;
                send_scan(len, invalid_pct, spread);
            end
            drain_scans();
        end
    endtask

    initial
    begin
        // Hold every input at a known level from time zero.
        rst_n                  = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.data            = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.cell_code    = '0;
        sample_ch.module_valid = 1'b0;
        sample_ch.last_cell    = 1'b0;
        report_ch.ready        = 1'b0;
        mismatches             = 0;
        cycle_count            = 0;
        items_sent             = 0;
        burst_left             = 0;
        sender_gaps            = 1'b1;
        stall_mode             = STALL_RANDOM;
        stall_tick             = 0;
        stall_hold             = 0;
        threshold              = THRESH_RESET;
        clear_scan();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_threshold();
        test_validity();
        test_extreme_codes();
        test_threshold_limits();
        test_cell_saturation();
        test_random_scans();

        drain_scans();
        if (mismatches == 0 && pending_summaries.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cim_pkg.sv
rtl/cim_if.sv
rtl/cim_tracker.sv
rtl/cell_imbalance_monitor.sv
rtl/cim_checker.sv
dv/testbench.sv
